// ----- design/ede_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_pkg
// Shared item kinds, output field widths and the control group that travels
// along the cell row.
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int DIST_W = 7;

    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = 7'd127;

    // control group handed from cell to cell
    typedef struct packed {
        logic byte_vld;   // a second-string byte sweeps along the row
        logic fin;        // finish marker: collect the distance and clear
    } ede_ctrl_t;

endpackage

// ----- design/ede_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_cell
// One cell of the row: holds one first-string byte and its column entry.
// ----------------------------------------------------------------------------
module ede_cell #(
    parameter int IDX = 1,
    parameter int VW  = 7
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load_en,
    input  logic [7:0]                load_char,
    input  ede_pkg::ede_ctrl_t        ctrl_in,
    input  logic [7:0]                byte_in,
    input  logic [VW-1:0]             new_in,
    input  logic [VW-1:0]             old_in,
    output ede_pkg::ede_ctrl_t        ctrl_out,
    output logic [7:0]                byte_out,
    output logic [VW-1:0]             new_out,
    output logic [VW-1:0]             old_out
);
    import ede_pkg::*;

    logic [BYTE_W-1:0] char_reg;
    logic              used_reg, used_next;
    logic [VW-1:0]     d_reg, d_next;
    ede_ctrl_t         ctrl_reg;
    logic [7:0]        byte_reg;
    logic [VW-1:0]     new_reg, new_next;
    logic [VW-1:0]     old_reg;

    logic [VW:0] up_cost, left_cost, diag_cost, min_ab, min_abc;

    // unit-cost recurrence: deletion, insertion, substitution
    always_comb begin
        up_cost   = {1'b0, d_reg} + {{VW{1'b0}}, 1'b1};
        left_cost = {1'b0, new_in} + {{VW{1'b0}}, 1'b1};
        diag_cost = {1'b0, old_in} + {{VW{1'b0}}, (char_reg != byte_in)};
        min_ab    = (up_cost < left_cost) ? up_cost : left_cost;
        min_abc   = (min_ab < diag_cost) ? min_ab : diag_cost;
    end

    always_comb begin
        d_next    = d_reg;
        used_next = used_reg;
        new_next  = new_in;
        if (load_en) begin
            used_next = 1'b1;
        end
        if (ctrl_in.byte_vld && used_reg) begin
            d_next   = min_abc[VW-1:0];
            new_next = min_abc[VW-1:0];
        end
        if (ctrl_in.fin) begin
            // last loaded cell wins: loaded cells form a prefix of the row
            if (used_reg) begin
                new_next = d_reg;
            end
            d_next    = VW'(IDX);
            used_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            d_reg    <= VW'(IDX);
            ctrl_reg <= '0;
        end else begin
            used_reg <= used_next;
            d_reg    <= d_next;
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            char_reg <= load_char;
        end
        byte_reg <= byte_in;
        new_reg  <= new_next;
        old_reg  <= d_reg;
    end

    assign ctrl_out = ctrl_reg;
    assign byte_out = byte_reg;
    assign new_out  = new_reg;
    assign old_out  = old_reg;

endmodule

// ----- design/edit_distance_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein edit distance between two byte strings on a systolic cell row.
// ----------------------------------------------------------------------------
// Load the first string with kind 0 items, one byte per cell, then stream the
// second string with kind 1 items; each second-string byte sweeps along a row
// of MAX_LEN cells, one cell per cycle, so kind 0 and kind 1 items are taken
// at one per cycle. A kind 2 item sends a finish marker after the last byte;
// it collects the distance from the last loaded cell and clears each cell as
// it passes. The result is registered once the marker has passed the entry
// stage and every cell of the row, and no further item is taken until the
// marker has left the row and the result has been taken. Bytes beyond MAX_LEN
// on either string are dropped and flagged in too_long; first-string bytes
// after the second string has started are ignored, as is kind 3. The
// distance saturates at 127.
// ----------------------------------------------------------------------------
module edit_distance_engine #(
    parameter int MAX_LEN = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic [1:0] s_tuser,   // [1:0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] distance, [7] too_long
);
    import ede_pkg::*;

    localparam int VW = $clog2(MAX_LEN + 1);
    localparam int CW = (VW > DIST_W) ? VW : DIST_W;

    // string lengths, overflow flag and finish-in-flight flag
    logic [VW-1:0] first_len_reg, first_len_next;
    logic [VW-1:0] second_len_reg, second_len_next;
    logic          ovf_reg, ovf_next;
    logic          busy_reg, busy_next;

    // entry stage ahead of the first cell: column entry zero
    ede_ctrl_t     ent_ctrl_reg, ent_ctrl_next;
    logic [7:0]    ent_byte_reg;
    logic [VW-1:0] ent_new_reg, ent_new_next;
    logic [VW-1:0] ent_old_reg;

    // result register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DIST_W-1:0] dist_reg;
    logic              too_long_reg;

    // links between cells, index 0 is the entry stage
    ede_ctrl_t     lnk_ctrl [0:MAX_LEN];
    logic [7:0]    lnk_byte [0:MAX_LEN];
    logic [VW-1:0] lnk_new  [0:MAX_LEN];
    logic [VW-1:0] lnk_old  [0:MAX_LEN];

    logic          in_fire, out_fire, first_fire, tok_exit;
    logic [CW-1:0] dist_wide;

    assign s_tready = !busy_reg && !m_tvalid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid_reg && m_tready;

    // a first-string byte is stored only before the second string starts
    assign first_fire = in_fire && (s_tuser == KIND_FIRST)
                        && (second_len_reg == '0)
                        && (first_len_reg < VW'(MAX_LEN));

    assign tok_exit = lnk_ctrl[MAX_LEN].fin;

    always_comb begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        busy_next       = busy_reg;
        ent_ctrl_next   = '0;
        ent_new_next    = second_len_reg + VW'(1);
        m_tvalid_next   = m_tvalid_reg;

        if (out_fire) begin
            m_tvalid_next = 1'b0;
        end

        if (in_fire) begin
            case (s_tuser)
                KIND_FIRST: begin
                    if (second_len_reg == '0) begin
                        if (first_len_reg < VW'(MAX_LEN)) begin
                            first_len_next = first_len_reg + VW'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                KIND_SECOND: begin
                    if (second_len_reg < VW'(MAX_LEN)) begin
                        second_len_next        = second_len_reg + VW'(1);
                        ent_ctrl_next.byte_vld = 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                KIND_FINISH: begin
                    // with no cells loaded the marker carries the second length
                    ent_ctrl_next.fin = 1'b1;
                    ent_new_next      = second_len_reg;
                    busy_next         = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // marker leaves the row: post the result and clear the counters
        if (tok_exit) begin
            busy_next       = 1'b0;
            m_tvalid_next   = 1'b1;
            first_len_next  = '0;
            second_len_next = '0;
            ovf_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            ent_ctrl_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
            busy_reg       <= busy_next;
            ent_ctrl_reg   <= ent_ctrl_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // saturate the collected distance to the output field
    assign dist_wide = CW'(lnk_new[MAX_LEN]);

    always_ff @(posedge aclk) begin
        ent_byte_reg <= s_tdata;
        ent_new_reg  <= ent_new_next;
        ent_old_reg  <= second_len_reg;
        if (tok_exit) begin
            dist_reg     <= (dist_wide > CW'(DIST_MAX)) ? DIST_MAX
                                                         : dist_wide[DIST_W-1:0];
            too_long_reg <= ovf_reg;
        end
    end

    assign lnk_ctrl[0] = ent_ctrl_reg;
    assign lnk_byte[0] = ent_byte_reg;
    assign lnk_new[0]  = ent_new_reg;
    assign lnk_old[0]  = ent_old_reg;

    // the row: cell g+1 holds first-string byte g
    for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
        ede_cell #(
            .IDX (g + 1),
            .VW  (VW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .load_en   (first_fire && (first_len_reg == VW'(g))),
            .load_char (s_tdata),
            .ctrl_in   (lnk_ctrl[g]),
            .byte_in   (lnk_byte[g]),
            .new_in    (lnk_new[g]),
            .old_in    (lnk_old[g]),
            .ctrl_out  (lnk_ctrl[g+1]),
            .byte_out  (lnk_byte[g+1]),
            .new_out   (lnk_new[g+1]),
            .old_out   (lnk_old[g+1])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {too_long_reg, dist_reg};

    // a result only follows a finish marker that was in flight
    a_result_after_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(busy_reg))
        else $error("result posted without a finish in flight");

    // the marker never leaves the row unless a finish was taken
    a_exit_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_exit |-> busy_reg)
        else $error("finish marker left the row unexpectedly");

    // lengths and flag are cleared once the result is posted
    a_cleared_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> (first_len_reg == '0) && (second_len_reg == '0)
                                && !ovf_reg)
        else $error("state not cleared after finish");

    // lengths stay within the row
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_len_reg <= VW'(MAX_LEN)) && (second_len_reg <= VW'(MAX_LEN)))
        else $error("string length beyond the row");

endmodule

// ----- tb/tb_edit_distance_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_edit_distance_engine
// Self-checking bench for the Levenshtein edit distance engine.
// ----------------------------------------------------------------------------
// A short directed sequence covers the corner cases: empty strings, byte
// extremes, ignored kinds and late first-string bytes. Random string pairs
// follow, with short strings and now and then ones that run past the length
// limit. The strings are drawn from a narrow or a full byte alphabet, and the
// second string is often a mutated copy of the first. Every taken item feeds
// a behavioural model of the DP column. Each finish queues the distance it
// should yield, and every result is checked against the oldest queued entry.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine;

    import ede_pkg::*;

    localparam int          STR_MAX     = 64;
    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          PHASE_ITEMS = 500;

    // kind 3 has no meaning to the block; it must be dropped silently
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              too_long;
    } distance_t;

    // ------------------------------------------------------------------------
    // Behavioural copy of the engine: string store, DP column and the queue of
    // distances still owed by the block.
    // ------------------------------------------------------------------------
    class distance_board;
        logic [BYTE_W-1:0] first_bytes [STR_MAX];
        int unsigned       column [STR_MAX+1];
        int unsigned       first_len;
        int unsigned       second_len;
        bit                overflow;
        distance_t         owed_q [$];
        int unsigned       failures;

        function new();
            failures = 0;
            clear();
        endfunction

        function void clear();
            for (int i = 0; i <= STR_MAX; i++) begin
                column[i] = i;
            end
            first_len  = 0;
            second_len = 0;
            overflow   = 1'b0;
        endfunction

        // Advance the model by one taken item.
        function void take_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] b);
            int unsigned diag;
            int unsigned above;
            int unsigned best;
            distance_t   owed;
            case (kind)
                KIND_FIRST: begin
                    // first-string bytes are frozen once the second string starts
                    if (second_len == 0) begin
                        if (first_len >= STR_MAX) begin
                            overflow = 1'b1;
                        end else begin
                            first_bytes[first_len] = b;
                            first_len++;
                        end
                    end
                end
                KIND_SECOND: begin
                    if (second_len >= STR_MAX) begin
                        overflow = 1'b1;
                    end else begin
                        diag = column[0];
                        second_len++;
                        column[0] = second_len;
                        for (int i = 1; i <= first_len; i++) begin
                            above = column[i];
                            best  = above + 1;
                            if (column[i-1] + 1 < best) best = column[i-1] + 1;
                            if (diag + (first_bytes[i-1] != b) < best)
                                best = diag + (first_bytes[i-1] != b);
                            column[i] = best;
                            diag = above;
                        end
                    end
                end
                KIND_FINISH: begin
                    best = column[first_len];
                    if (best > DIST_MAX) best = DIST_MAX;
                    owed.distance = best[DIST_W-1:0];
                    owed.too_long = overflow;
                    owed_q.insert(owed_q.size(), owed);
                    clear();
                end
                default: ;
            endcase
        endfunction

        // Compare one taken result with the oldest owed distance.
        function void check_result(logic [DIST_W-1:0] distance, logic too_long);
            distance_t owed;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, distance %0d too_long %0b",
                         $time, distance, too_long);
                failures++;
            end else begin
                owed = owed_q.pop_front();
                if (distance !== owed.distance) begin
                    $display("%0t: distance mismatch, expected %0d actual %0d",
                             $time, owed.distance, distance);
                    failures++;
                end
                if (too_long !== owed.too_long) begin
                    $display("%0t: too_long mismatch, expected %0b actual %0b",
                             $time, owed.too_long, too_long);
                    failures++;
                end
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and bench state
    // ------------------------------------------------------------------------
    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;    // [7:0] char_byte
    logic [1:0]        s_tuser;    // [1:0] kind
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;    // [6:0] distance, [7] too_long

    distance_board     sb;
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                hold_request;
    int                items_sent;
    int unsigned       cycle_count;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    edit_distance_engine #(
        .MAX_LEN (STR_MAX)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Sample both channels on the rising edge; drive happens on the falling one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata[6:0], m_tdata[7]);
        end
    end

    // Result side: random back-pressure, plus one long hold when asked for.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Abort a hung run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one item; idle first at random, then hold it until it is taken.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte(bit narrow, logic [BYTE_W-1:0] base);
        if (narrow) return base + BYTE_W'($urandom_range(3));
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic int pick_len();
        // mostly short strings; now and then one around the limit
        if ($urandom_range(99) < 8) return $urandom_range(STR_MAX + 2, STR_MAX - 2);
        return $urandom_range(8);
    endfunction

    // One string pair with random content, occasionally broken on purpose.
    task automatic send_run();
        logic [BYTE_W-1:0] first_run [STR_MAX+3];
        logic [BYTE_W-1:0] b;
        int                len1;
        int                len2;
        bit                narrow;
        bit                broken;
        logic [BYTE_W-1:0] base;
        len1   = pick_len();
        len2   = pick_len();
        narrow = 1'($urandom_range(1));
        broken = ($urandom_range(99) < 10);
        base   = BYTE_W'($urandom_range(255));

        for (int j = 0; j < len1; j++) begin
            first_run[j] = pick_byte(narrow, base);
            send_item(KIND_FIRST, first_run[j]);
            items_sent++;
        end
        if (broken) send_item(KIND_UNUSED, BYTE_W'($urandom_range(255)));
        for (int j = 0; j < len2; j++) begin
            // keep most of the first string so small distances turn up
            if (j < len1 && $urandom_range(3) != 0) b = first_run[j];
            else b = pick_byte(narrow, base);
            send_item(KIND_SECOND, b);
            items_sent++;
            // a late first-string byte must leave the column alone
            if (broken && j == 0) send_item(KIND_FIRST, BYTE_W'($urandom_range(255)));
        end
        // now and then let the run carry on into the next one
        if ($urandom_range(99) >= 5) begin
            send_item(KIND_FINISH, BYTE_W'($urandom_range(255)));
            items_sent++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb            = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        hold_request  = 1'b0;
        items_sent    = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // both strings empty
        send_item(KIND_FINISH, 8'h00);
        // empty first string, byte extremes on the second
        send_item(KIND_SECOND, 8'h00);
        send_item(KIND_SECOND, 8'hFF);
        send_item(KIND_FINISH, 8'hFF);
        // empty second string
        send_item(KIND_FIRST, 8'hFF);
        send_item(KIND_FIRST, 8'h00);
        send_item(KIND_FINISH, 8'h5A);
        // one insertion, with an unused kind and a late first-string byte
        send_item(KIND_FIRST, 8'h61);
        send_item(KIND_FIRST, 8'h62);
        send_item(KIND_UNUSED, 8'h5A);
        send_item(KIND_SECOND, 8'h61);
        send_item(KIND_SECOND, 8'h63);
        send_item(KIND_FIRST, 8'hFF);
        send_item(KIND_SECOND, 8'h62);
        send_item(KIND_FINISH, 8'h00);
        // equal single bytes
        send_item(KIND_FIRST, 8'h80);
        send_item(KIND_SECOND, 8'h80);
        send_item(KIND_FINISH, 8'h7F);
        // all substitutions
        send_item(KIND_FIRST, 8'h01);
        send_item(KIND_FIRST, 8'h02);
        send_item(KIND_SECOND, 8'hFE);
        send_item(KIND_SECOND, 8'hFD);
        send_item(KIND_FINISH, 8'h00);

        // random phases: sender-light idling, receiver-light idling, none
        items_sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 14; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 14; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // stall the result side so the engine backs up its input
                    hold_request  = 1'b1;
                end
            endcase
            while (items_sent < PHASE_ITEMS * (phase + 1)) send_run();
        end
        // close off any run left open
        send_item(KIND_FINISH, 8'h00);

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // drain, then allow the row to settle
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (STR_MAX + 8) @(posedge aclk);

        if (sb.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
